// ===== rtl/jdcal_pkg.sv =====
// Shared constants, types and tables for the Julian day to calendar date converter.
// Used by jdcal_tod and jd_to_calendar_date; depends on nothing.
`default_nettype none

package jdcal_pkg;

    // Field widths
    localparam int DAY_NUM_W = 23;
    localparam int SECS_W    = 17;
    localparam int YEAR_W    = 16;
    localparam int MONTH_W   = 4;
    localparam int DOM_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;

    // Depth from input register to output register, in stages
    localparam int PIPE_DEPTH = 8;

    // Calendar switch and Gregorian correction: alpha = (4z - 7468865) / 146097
    localparam logic [DAY_NUM_W-1:0] CAL_SWITCH_DAY = 23'd2299161;
    localparam logic [24:0]          GREG_OFFSET    = 25'd7468865;
    localparam logic [17:0]          GREG_DIV       = 18'd146097;
    localparam logic [14:0]          GREG_RECIP     = 15'd29398;   // floor(2^32 / 146097)

    // Year split: c = (20b - 2442) / 7305
    localparam logic [27:0] YEAR_OFFSET = 28'd2442;
    localparam logic [12:0] YEAR_DIV    = 13'd7305;
    localparam logic [19:0] YEAR_RECIP  = 20'd587948;             // floor(2^32 / 7305)
    localparam logic [10:0] DAYS_4YR    = 11'd1461;

    // Time of day
    localparam logic [SECS_W-1:0] LAST_SECOND = 17'd86399;
    localparam logic [15:0]       HOUR_RECIP  = 16'd37283;        // ceil(2^27 / 3600), exact
    localparam logic [11:0]       SECS_HOUR   = 12'd3600;
    localparam logic [12:0]       MIN_RECIP   = 13'd4370;         // ceil(2^18 / 60), exact
    localparam logic [5:0]        SECS_MIN    = 6'd60;

    // Time of day as it travels down the pipeline
    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } t_tod;

    // floor(30.6001 * e): days before month index e, counted from March
    function automatic logic [8:0] month_start(input logic [3:0] e);
        logic [8:0] v;
        case (e)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd397;
            4'd14:   v = 9'd428;
            4'd15:   v = 9'd459;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/jdcal_tod.sv =====
// Time-of-day split: seconds of day into hour, minute and second, pipelined.
// Depends on jdcal_pkg; output lines up with the date path after PIPE_DEPTH stages.
`default_nettype none

module jdcal_tod (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [jdcal_pkg::SECS_W-1:0] i_secs,
    output jdcal_pkg::t_tod                  o_tod
);
    import jdcal_pkg::*;

    localparam int DLY = PIPE_DEPTH - 4;

    logic [SECS_W-1:0] n_s;
    logic [32:0]       n_hprod;
    logic [SECS_W-1:0] r1_s;
    logic [HOUR_W-1:0] r1_h;
    logic [16:0]       n_hsec;
    logic [11:0]       n_rem;
    logic [11:0]       r2_rem;
    logic [HOUR_W-1:0] r2_h;
    logic [24:0]       n_mprod;
    logic [11:0]       r3_rem;
    logic [MINUTE_W-1:0] r3_m;
    logic [HOUR_W-1:0] r3_h;
    logic [11:0]       n_msec;
    t_tod              n_tod;
    t_tod              r_dly [DLY+1];

    // Saturate seconds and estimate the hour by exact reciprocal
    always_comb begin
        n_s     = (i_secs > LAST_SECOND) ? LAST_SECOND : i_secs;
        n_hprod = 33'(n_s) * 33'(HOUR_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_s <= n_s;
            r1_h <= n_hprod[31:27];
        end
    end

    // Remove whole hours
    always_comb begin
        n_hsec = 17'(r1_h) * 17'(SECS_HOUR);
        n_rem  = 12'(r1_s - n_hsec);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_rem <= n_rem;
            r2_h   <= r1_h;
        end
    end

    // Minute by exact reciprocal of 60
    assign n_mprod = 25'(r2_rem) * 25'(MIN_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_rem <= r2_rem;
            r3_m   <= n_mprod[23:18];
            r3_h   <= r2_h;
        end
    end

    // Second is what remains after whole minutes
    always_comb begin
        n_msec        = 12'(r3_m) * 12'(SECS_MIN);
        n_tod.hour    = r3_h;
        n_tod.minute  = r3_m;
        n_tod.second  = 6'(r3_rem - n_msec);
    end

    // Hold the result until the date path catches up
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly[0] <= n_tod;
            for (int k = 1; k <= DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign o_tod = r_dly[DLY];

endmodule

`default_nettype wire

// ===== rtl/jd_to_calendar_date.sv =====
// Julian day number plus seconds of day to calendar date and time of day.
// Top level; depends on jdcal_pkg and jdcal_tod.
//
// Takes one word per clock and returns one word per clock while the output is not
// stalled. The date path is an eight-stage pipeline: each constant division
// (by 146097, by 7305) is a reciprocal multiply followed by a multiply-and-correct
// stage, and the month split is a row of parallel compares against a 16-entry
// table. A stall on the output freezes every stage at once, so the input is ready
// whenever the output register is empty or being taken. Day numbers from 2299161
// on get the Gregorian correction; seconds above 86399 read as 23:59:59.
`default_nettype none

module jd_to_calendar_date (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [jdcal_pkg::DAY_NUM_W-1:0]  i_day_number,
    input  wire logic [jdcal_pkg::SECS_W-1:0]     i_seconds_of_day,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic signed [jdcal_pkg::YEAR_W-1:0]   o_year,
    output logic [jdcal_pkg::MONTH_W-1:0]         o_month,
    output logic [jdcal_pkg::DOM_W-1:0]           o_day_of_month,
    output logic [jdcal_pkg::HOUR_W-1:0]          o_hour,
    output logic [jdcal_pkg::MINUTE_W-1:0]        o_minute,
    output logic [jdcal_pkg::SECOND_W-1:0]        o_second
);
    import jdcal_pkg::*;

    logic                  w_en;
    logic [PIPE_DEPTH-1:0] r_vld;
    t_tod                  w_tod;

    // Stage 1
    logic [24:0]           n_x1;
    logic [39:0]           n_p1;
    logic [24:0]           r1_x;
    logic [7:0]            r1_q;
    logic [DAY_NUM_W-1:0]  r1_z;
    logic                  r1_greg;
    // Stage 2
    logic [25:0]           n_qk1;
    logic [24:0]           n_rem1;
    logic [7:0]            r2_alpha;
    logic [DAY_NUM_W-1:0]  r2_z;
    logic                  r2_greg;
    // Stage 3
    logic [23:0]           n_b;
    logic [27:0]           n_x2;
    logic [23:0]           r3_b;
    logic [27:0]           r3_x2;
    // Stage 4
    logic [47:0]           n_p2;
    logic [14:0]           r4_q;
    logic [27:0]           r4_x2;
    logic [23:0]           r4_b;
    // Stage 5
    logic [27:0]           n_qk2;
    logic [27:0]           n_rem2;
    logic [14:0]           r5_c;
    logic [23:0]           r5_b;
    // Stage 6
    logic [25:0]           n_c4;
    logic [23:0]           n_bd;
    logic [8:0]            r6_bd;
    logic [14:0]           r6_c;
    // Stage 7
    logic [3:0]            n_e;
    logic [3:0]            r7_e;
    logic [8:0]            r7_bd;
    logic [14:0]           r7_c;
    // Stage 8
    logic [MONTH_W-1:0]    n_month;
    logic [DOM_W-1:0]      n_dom;
    logic [YEAR_W-1:0]     n_year;
    logic [YEAR_W-1:0]     r8_year;
    logic [MONTH_W-1:0]    r8_month;
    logic [DOM_W-1:0]      r8_dom;

    // Advance the whole pipe unless the output word is held
    assign w_en       = !r_vld[PIPE_DEPTH-1] || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    // Time of day runs alongside
    jdcal_tod u_tod (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_secs (i_seconds_of_day),
        .o_tod  (w_tod)
    );

    // Stage 1: estimate alpha by reciprocal
    always_comb begin
        n_x1 = {i_day_number, 2'b00} - GREG_OFFSET;
        n_p1 = 40'(n_x1) * 40'(GREG_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x    <= n_x1;
            r1_q    <= n_p1[39:32];
            r1_z    <= i_day_number;
            r1_greg <= (i_day_number >= CAL_SWITCH_DAY);
        end
    end

    // Stage 2: correct the alpha estimate by one
    always_comb begin
        n_qk1  = 26'(r1_q) * 26'(GREG_DIV);
        n_rem1 = r1_x - n_qk1[24:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_alpha <= r1_q + 8'(n_rem1 >= 25'(GREG_DIV));
            r2_z     <= r1_z;
            r2_greg  <= r1_greg;
        end
    end

    // Stage 3: apply century correction, form b and 20b - 2442
    always_comb begin
        if (r2_greg) begin
            n_b = 24'(r2_z) + 24'd1525 + 24'(r2_alpha) - 24'(r2_alpha >> 2);
        end else begin
            n_b = 24'(r2_z) + 24'd1524;
        end
        n_x2 = {n_b, 4'b0000} + {2'b00, n_b, 2'b00} - YEAR_OFFSET;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_b  <= n_b;
            r3_x2 <= n_x2;
        end
    end

    // Stage 4: estimate c by reciprocal
    assign n_p2 = 48'(r3_x2) * 48'(YEAR_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_q  <= n_p2[46:32];
            r4_x2 <= r3_x2;
            r4_b  <= r3_b;
        end
    end

    // Stage 5: correct the c estimate by one
    always_comb begin
        n_qk2  = 28'(r4_q) * 28'(YEAR_DIV);
        n_rem2 = r4_x2 - n_qk2;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_c <= r4_q + 15'(n_rem2 >= 28'(YEAR_DIV));
            r5_b <= r4_b;
        end
    end

    // Stage 6: days left in the year counted from March
    always_comb begin
        n_c4 = 26'(r5_c) * 26'(DAYS_4YR);
        n_bd = r5_b - n_c4[25:2];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_bd <= n_bd[8:0];
            r6_c  <= r5_c;
        end
    end

    // Stage 7: month index is the number of month starts passed
    always_comb begin
        n_e = '0;
        for (int k = 1; k < 16; k++) begin
            n_e = n_e + 4'(r6_bd > month_start(4'(k)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_e  <= n_e;
            r7_bd <= r6_bd;
            r7_c  <= r6_c;
        end
    end

    // Stage 8: final day, month and year
    always_comb begin
        n_dom   = 5'(r7_bd - month_start(r7_e));
        n_month = (r7_e < 4'd14) ? (r7_e - 4'd1) : (r7_e - 4'd13);
        n_year  = 16'(r7_c) - ((n_month > 4'd2) ? 16'd4716 : 16'd4715);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_year  <= n_year;
            r8_month <= n_month;
            r8_dom   <= n_dom;
        end
    end

    assign o_out_valid    = r_vld[PIPE_DEPTH-1];
    assign o_year         = signed'(r8_year);
    assign o_month        = r8_month;
    assign o_day_of_month = r8_dom;
    assign o_hour         = w_tod.hour;
    assign o_minute       = w_tod.minute;
    assign o_second       = w_tod.second;

`ifndef SYNTH
    // A held output word freezes every valid bit
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    // An accepted word enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted word not captured");

    // Date fields stay in their calendar range
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_month >= 4'd1 && o_month <= 4'd12 &&
                         o_day_of_month >= 5'd1 && o_day_of_month <= 5'd31))
        else $error("date field out of range");

    // Time fields stay in their clock range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59))
        else $error("time field out of range");
`endif

endmodule

`default_nettype wire

// ===== test/tb_jd_to_calendar_date.sv =====
`timescale 1ns / 1ps
// Testbench for jd_to_calendar_date: directed table followed by random day numbers and times.
// Depends on jdcal_pkg for field widths and pipeline depth; checks every word against a typed date or a predictor.

module tb_jd_to_calendar_date;

    import jdcal_pkg::*;

    localparam int          RANDOM_WORDS = 1830;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          PRINT_CAP    = 40;
    localparam longint      GREG_START   = 2299161;
    localparam longint      DAY_MAX      = (1 << DAY_NUM_W) - 1;
    localparam longint      SECS_MAX     = (1 << SECS_W) - 1;
    localparam longint      LAST_SEC     = 86399;

    // One calendar date and time of day, at the block's output widths
    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DOM_W-1:0]         day_of_month;
        logic [HOUR_W-1:0]        hour;
        logic [MINUTE_W-1:0]      minute;
        logic [SECOND_W-1:0]      second;
    } t_cal_stamp;

    typedef struct {
        logic [DAY_NUM_W-1:0] jd;
        logic [SECS_W-1:0]    secs;
        bit                   typed;
        t_cal_stamp           stamp;
    } t_directed_row;

    logic                        i_clk;
    logic                        i_rst_n          = 1'b0;
    logic                        i_in_valid       = 1'b0;
    logic                        o_in_ready;
    logic [DAY_NUM_W-1:0]        i_day_number     = '0;
    logic [SECS_W-1:0]           i_seconds_of_day = '0;
    logic                        o_out_valid;
    logic                        i_out_ready      = 1'b0;
    logic signed [YEAR_W-1:0]    o_year;
    logic [MONTH_W-1:0]          o_month;
    logic [DOM_W-1:0]            o_day_of_month;
    logic [HOUR_W-1:0]           o_hour;
    logic [MINUTE_W-1:0]         o_minute;
    logic [SECOND_W-1:0]         o_second;

    t_cal_stamp    pending_dates[$];
    t_directed_row directed_rows[$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    bit            burst_mode     = 1'b0;

    jd_to_calendar_date dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_day_number     (i_day_number),
        .i_seconds_of_day (i_seconds_of_day),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_year           (o_year),
        .o_month          (o_month),
        .o_day_of_month   (o_day_of_month),
        .o_hour           (o_hour),
        .o_minute         (o_minute),
        .o_second         (o_second)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Meeus conversion with exact integer divisions; seconds saturate at end of day
    function automatic t_cal_stamp convert_jd(input logic [DAY_NUM_W-1:0] jd,
                                              input logic [SECS_W-1:0] secs);
        longint     z, a, b, c, d, bd, e, alpha, mon, s, yr;
        t_cal_stamp r;
        z = longint'(jd);
        if (z < GREG_START) begin
            a = z;
        end else begin
            alpha = (4 * z - 7468865) / 146097;
            a = z + 1 + alpha - alpha / 4;
        end
        b   = a + 1524;
        c   = (20 * b - 2442) / 7305;
        d   = (1461 * c) / 4;
        bd  = b - d;
        e   = (10000 * bd) / 306001;
        mon = (e < 14) ? e - 1 : e - 13;
        yr  = c - ((mon > 2) ? 4716 : 4715);
        s   = (longint'(secs) > LAST_SEC) ? LAST_SEC : longint'(secs);
        r.year         = yr[YEAR_W-1:0];
        r.month        = mon[MONTH_W-1:0];
        r.day_of_month = DOM_W'(bd - (306001 * e) / 10000);
        r.hour         = HOUR_W'(s / 3600);
        r.minute       = MINUTE_W'((s % 3600) / 60);
        r.second       = SECOND_W'(s % 60);
        return r;
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return int'($urandom_range(1, 3));
        if (r < 95) return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic logic [DAY_NUM_W-1:0] pick_day();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return DAY_NUM_W'($urandom_range(0, DAY_MAX));
        if (r < 50) return DAY_NUM_W'(GREG_START - 1000 + $urandom_range(0, 2000));
        if (r < 75) return DAY_NUM_W'($urandom_range(2400000, 2500000));
        if (r < 90) return DAY_NUM_W'($urandom_range(0, GREG_START - 1));
        return DAY_NUM_W'(DAY_MAX - $urandom_range(0, 100000));
    endfunction

    function automatic logic [SECS_W-1:0] pick_secs();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return SECS_W'($urandom_range(0, LAST_SEC));
        if (r < 92) begin
            case ($urandom_range(0, 5))
                0:       return SECS_W'(0);
                1:       return SECS_W'(59);
                2:       return SECS_W'(60);
                3:       return SECS_W'(3599);
                4:       return SECS_W'(3600);
                default: return SECS_W'(LAST_SEC);
            endcase
        end
        return SECS_W'($urandom_range(LAST_SEC + 1, SECS_MAX));
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic add_row(input int jd, input int secs,
                           input bit typed, input int yr, input int mo, input int dm,
                           input int hh, input int mi, input int ss);
        t_directed_row row;
        row.jd                 = DAY_NUM_W'(jd);
        row.secs               = SECS_W'(secs);
        row.typed              = typed;
        row.stamp.year         = YEAR_W'(yr);
        row.stamp.month        = MONTH_W'(mo);
        row.stamp.day_of_month = DOM_W'(dm);
        row.stamp.hour         = HOUR_W'(hh);
        row.stamp.minute       = MINUTE_W'(mi);
        row.stamp.second       = SECOND_W'(ss);
        directed_rows.push_back(row);
    endtask

    // Present one word, hold it until taken, then queue its expected date
    task automatic send_word(input logic [DAY_NUM_W-1:0] jd, input logic [SECS_W-1:0] secs,
                             input bit typed, input t_cal_stamp stamp);
        int gap;
        gap = (!burst_mode && $urandom_range(0, 99) < 30) ? pick_idle() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_day_number     <= jd;
        i_seconds_of_day <= secs;
        do @(posedge i_clk); while (!o_in_ready);
        pending_dates.push_back(typed ? stamp : convert_jd(jd, secs));
    endtask

    // Throttle the output side with random stalls
    always @(posedge i_clk) begin : out_throttle
        int stall_left;
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if (!burst_mode && $urandom_range(0, 99) < 20) begin
            i_out_ready <= 1'b0;
            stall_left = pick_idle() - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each taken word against the oldest expectation
    always @(posedge i_clk) begin : date_check
        t_cal_stamp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_dates.size() == 0) begin
                report_mismatch("unexpected word, queue depth", 0, 0);
            end else begin
                want = pending_dates.pop_front();
                if (o_year !== want.year)
                    report_mismatch("year", longint'(o_year), longint'(want.year));
                if (o_month !== want.month)
                    report_mismatch("month", longint'(o_month), longint'(want.month));
                if (o_day_of_month !== want.day_of_month)
                    report_mismatch("day_of_month", longint'(o_day_of_month),
                                    longint'(want.day_of_month));
                if (o_hour !== want.hour)
                    report_mismatch("hour", longint'(o_hour), longint'(want.hour));
                if (o_minute !== want.minute)
                    report_mismatch("minute", longint'(o_minute), longint'(want.minute));
                if (o_second !== want.second)
                    report_mismatch("second", longint'(o_second), longint'(want.second));
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_cal_stamp none;
        none = '0;

        // Directed table: typed rows are dates read straight off the calendar
        add_row(0,       0,      1, -4712,  1,  1,  0,  0,  0);
        add_row(0,       86399,  1, -4712,  1,  1, 23, 59, 59);
        add_row(0,       86400,  1, -4712,  1,  1, 23, 59, 59);
        add_row(0,       131071, 1, -4712,  1,  1, 23, 59, 59);
        add_row(2299160, 0,      1,  1582, 10,  4,  0,  0,  0);
        add_row(2299161, 0,      1,  1582, 10, 15,  0,  0,  0);
        add_row(2451545, 43200,  1,  2000,  1,  1, 12,  0,  0);
        add_row(1,       1,      0, 0, 0, 0, 0, 0, 0);
        add_row(2,       59,     0, 0, 0, 0, 0, 0, 0);
        add_row(59,      60,     0, 0, 0, 0, 0, 0, 0);
        add_row(60,      3599,   0, 0, 0, 0, 0, 0, 0);
        add_row(365,     3600,   0, 0, 0, 0, 0, 0, 0);
        add_row(2299159, 43199,  0, 0, 0, 0, 0, 0, 0);
        add_row(2299162, 65536,  0, 0, 0, 0, 0, 0, 0);
        add_row(1721424, 12345,  0, 0, 0, 0, 0, 0, 0);
        add_row(2415079, 7200,   0, 0, 0, 0, 0, 0, 0);
        add_row(2440588, 0,      0, 0, 0, 0, 0, 0, 0);
        add_row(2451604, 86399,  0, 0, 0, 0, 0, 0, 0);
        add_row(4194304, 100000, 0, 0, 0, 0, 0, 0, 0);
        add_row(4194303, 65535,  0, 0, 0, 0, 0, 0, 0);
        add_row(8388606, 86399,  0, 0, 0, 0, 0, 0, 0);
        add_row(8388607, 0,      0, 0, 0, 0, 0, 0, 0);
        add_row(8388607, 131071, 0, 0, 0, 0, 0, 0, 0);

        // Hold reset, then release
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_word(directed_rows[k].jd, directed_rows[k].secs,
                      directed_rows[k].typed, directed_rows[k].stamp);

        // Random words; switch between throttled and back-to-back stretches
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 100 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            send_word(pick_day(), pick_secs(), 1'b0, none);
        end
        burst_mode = 1'b0;
        i_in_valid <= 1'b0;

        // Drain, then let the pipeline settle
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== jd_to_calendar_date.f =====
rtl/jdcal_pkg.sv
rtl/jdcal_tod.sv
rtl/jd_to_calendar_date.sv
test/tb_jd_to_calendar_date.sv
